// ----- design/bccd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bccd_pkg
// Shared widths, register indexes, event codes and phase codes for the
// button chord click detector.
// ----------------------------------------------------------------------------
package bccd_pkg;

    // Number of debounced buttons (1..32); raw levels beyond eight read low
    localparam int BUTTONS   = 8;
    localparam int WIDE_W    = 32;
    localparam int HIST_W    = 4;

    localparam int RAW_W     = 8;
    localparam int ELAPSED_W = 16;
    localparam int MASK_W    = 8;
    localparam int EVSEL_W   = 3;
    localparam int TIME_W    = 16;
    localparam int PHASE_W   = 3;
    localparam int COUNT_W   = 8;

    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHORD_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_SEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_TIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME  = 2'd3;

    // Register reset values
    localparam logic [MASK_W-1:0]  CHORD_MASK_RST = 8'd1;
    localparam logic [EVSEL_W-1:0] EVENT_SEL_RST  = 3'd3;
    localparam logic [TIME_W-1:0]  CLICK_TIME_RST = 16'd300;
    localparam logic [TIME_W-1:0]  LONG_TIME_RST  = 16'd1000;

    // Event codes
    localparam logic [EVSEL_W-1:0] EV_DOWN       = 3'd0;
    localparam logic [EVSEL_W-1:0] EV_UP         = 3'd1;
    localparam logic [EVSEL_W-1:0] EV_REPEAT     = 3'd2;
    localparam logic [EVSEL_W-1:0] EV_CLICK      = 3'd3;
    localparam logic [EVSEL_W-1:0] EV_DOUBLE     = 3'd4;
    localparam logic [EVSEL_W-1:0] EV_LONG_START = 3'd5;
    localparam logic [EVSEL_W-1:0] EV_LONG_HOLD  = 3'd6;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_FIRST  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_REPEAT = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LONG   = 3'd4;

    localparam logic [HIST_W-1:0]  HIST_ALL_HIGH = 4'hf;
    localparam logic [HIST_W-1:0]  HIST_ALL_LOW  = 4'h0;
    localparam logic [TIME_W-1:0]  TIMER_MAX     = 16'hffff;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'hff;

endpackage

// ----- design/button_chord_click_detector_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_chord_click_detector_core
// Debounces up to BUTTONS raw levels, forms a masked chord and runs the
// click / double click / long press state machine, one tick per transaction.
// ----------------------------------------------------------------------------
//  Channel   Direction  Fields (low bit first)
//  s_*       in         raw_levels[7:0], elapsed_ms[23:8]
//  m_*       out        fire[0], debounced_levels[8:1], chord_pressed[9],
//                       phase[12:10], press_count_out[20:13]
//  cfg_*     in         write enable, index 0..3, 16-bit data
//
//  A tick is processed in the cycle it is accepted; its result appears in the
//  output register on the next cycle. Sustained rate is one tick per cycle
//  while m_tready is high. s_tready is low only while the output register
//  holds a result and m_tready is low. Reset (aresetn low, synchronous) clears
//  all state but the output data register and loads the register defaults.
// ----------------------------------------------------------------------------
module button_chord_click_detector_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // raw_levels[7:0], elapsed_ms[23:8]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bccd_pkg::S_DATA_W-1:0]      s_tdata,
    // fire, debounced_levels, chord_pressed, phase, press_count_out, pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bccd_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [bccd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bccd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // Configuration registers
    logic [bccd_pkg::MASK_W-1:0]  chord_mask_reg;
    logic [bccd_pkg::EVSEL_W-1:0] event_sel_reg;
    logic [bccd_pkg::TIME_W-1:0]  click_time_reg;
    logic [bccd_pkg::TIME_W-1:0]  long_time_reg;

    // Tick state
    logic [bccd_pkg::HIST_W-1:0]  hist_reg [bccd_pkg::BUTTONS];
    logic [bccd_pkg::HIST_W-1:0]  hist_next [bccd_pkg::BUTTONS];
    logic [bccd_pkg::BUTTONS-1:0] deb_reg, deb_next;
    logic [bccd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [bccd_pkg::TIME_W-1:0]  timer_reg, timer_next;
    logic [bccd_pkg::COUNT_W-1:0] count_reg, count_next;

    // Output register
    logic                          out_valid_reg;
    logic [bccd_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;

    logic                          s_accept;
    logic [bccd_pkg::RAW_W-1:0]    raw;
    logic [bccd_pkg::ELAPSED_W-1:0] elapsed;
    logic [bccd_pkg::WIDE_W-1:0]   raw_wide, deb_wide;
    logic [bccd_pkg::BUTTONS-1:0]  raw_ext;
    logic [bccd_pkg::MASK_W-1:0]   deb8;
    logic                          pressed;
    logic [bccd_pkg::TIME_W:0]     timer_sum;
    logic [bccd_pkg::TIME_W-1:0]   timer_adv;
    logic                          fire;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign raw     = s_tdata[bccd_pkg::RAW_W-1:0];
    assign elapsed = s_tdata[bccd_pkg::RAW_W +: bccd_pkg::ELAPSED_W];

    // Buttons beyond the raw field read low
    assign raw_wide = bccd_pkg::WIDE_W'(raw);
    assign raw_ext  = raw_wide[bccd_pkg::BUTTONS-1:0];

    // Shift debounce per button
    always_comb begin
        deb_next = deb_reg;
        for (int i = 0; i < bccd_pkg::BUTTONS; i++) begin
            hist_next[i] = {hist_reg[i][bccd_pkg::HIST_W-2:0], raw_ext[i]};
            if (hist_next[i] == bccd_pkg::HIST_ALL_HIGH) begin
                deb_next[i] = 1'b1;
            end else if (hist_next[i] == bccd_pkg::HIST_ALL_LOW) begin
                deb_next[i] = 1'b0;
            end
        end
    end

    // Chord over the low eight buttons; absent buttons count as released
    assign deb_wide = bccd_pkg::WIDE_W'(deb_next);
    assign deb8     = deb_wide[bccd_pkg::MASK_W-1:0];
    assign pressed  = (deb8 & chord_mask_reg) == chord_mask_reg;

    // Saturating timer advance
    assign timer_sum = {1'b0, timer_reg} + {1'b0, elapsed};
    assign timer_adv = timer_sum[bccd_pkg::TIME_W] ? bccd_pkg::TIMER_MAX
                                                   : timer_sum[bccd_pkg::TIME_W-1:0];

    // Click state machine
    always_comb begin
        phase_next = phase_reg;
        timer_next = timer_adv;
        count_next = count_reg;
        fire       = 1'b0;
        case (phase_reg)
            bccd_pkg::PH_IDLE: begin
                if (pressed) begin
                    fire       = (event_sel_reg == bccd_pkg::EV_DOWN);
                    timer_next = '0;
                    count_next = bccd_pkg::COUNT_W'(1);
                    phase_next = bccd_pkg::PH_FIRST;
                end
            end
            bccd_pkg::PH_FIRST: begin
                if (!pressed) begin
                    fire       = (event_sel_reg == bccd_pkg::EV_UP);
                    timer_next = '0;
                    phase_next = bccd_pkg::PH_WAIT;
                end else if (timer_adv > long_time_reg) begin
                    fire       = (event_sel_reg == bccd_pkg::EV_LONG_START);
                    phase_next = bccd_pkg::PH_LONG;
                end
            end
            bccd_pkg::PH_WAIT: begin
                if (pressed) begin
                    fire = (event_sel_reg == bccd_pkg::EV_DOWN) ||
                           (event_sel_reg == bccd_pkg::EV_REPEAT);
                    if (count_reg != bccd_pkg::COUNT_MAX) begin
                        count_next = count_reg + 1'b1;
                    end
                    timer_next = '0;
                    phase_next = bccd_pkg::PH_REPEAT;
                end else if (timer_adv > click_time_reg) begin
                    fire = ((count_reg == bccd_pkg::COUNT_W'(1)) &&
                            (event_sel_reg == bccd_pkg::EV_CLICK)) ||
                           ((count_reg == bccd_pkg::COUNT_W'(2)) &&
                            (event_sel_reg == bccd_pkg::EV_DOUBLE));
                    phase_next = bccd_pkg::PH_IDLE;
                end
            end
            bccd_pkg::PH_REPEAT: begin
                if (!pressed) begin
                    fire = (event_sel_reg == bccd_pkg::EV_UP);
                    if (timer_adv < click_time_reg) begin
                        timer_next = '0;
                        phase_next = bccd_pkg::PH_WAIT;
                    end else begin
                        phase_next = bccd_pkg::PH_IDLE;
                    end
                end else if (timer_adv > click_time_reg) begin
                    phase_next = bccd_pkg::PH_IDLE;
                end
            end
            bccd_pkg::PH_LONG: begin
                if (pressed) begin
                    fire = (event_sel_reg == bccd_pkg::EV_LONG_HOLD);
                end else begin
                    fire       = (event_sel_reg == bccd_pkg::EV_UP);
                    phase_next = bccd_pkg::PH_IDLE;
                end
            end
            default: begin
                phase_next = bccd_pkg::PH_IDLE;
            end
        endcase
    end

    // Result packing
    assign out_data_next = bccd_pkg::M_DATA_W'({count_next, phase_next, pressed,
                                                deb8, fire});

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chord_mask_reg <= bccd_pkg::CHORD_MASK_RST;
            event_sel_reg  <= bccd_pkg::EVENT_SEL_RST;
            click_time_reg <= bccd_pkg::CLICK_TIME_RST;
            long_time_reg  <= bccd_pkg::LONG_TIME_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bccd_pkg::REG_CHORD_MASK: begin
                    chord_mask_reg <= cfg_wdata[bccd_pkg::MASK_W-1:0];
                end
                bccd_pkg::REG_EVENT_SEL: begin
                    event_sel_reg <= cfg_wdata[bccd_pkg::EVSEL_W-1:0];
                end
                bccd_pkg::REG_CLICK_TIME: begin
                    click_time_reg <= cfg_wdata[bccd_pkg::TIME_W-1:0];
                end
                bccd_pkg::REG_LONG_TIME: begin
                    long_time_reg <= cfg_wdata[bccd_pkg::TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Tick state update on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bccd_pkg::BUTTONS; i++) begin
                hist_reg[i] <= '0;
            end
            deb_reg   <= '0;
            phase_reg <= bccd_pkg::PH_IDLE;
            timer_reg <= '0;
            count_reg <= '0;
        end else if (s_accept) begin
            for (int i = 0; i < bccd_pkg::BUTTONS; i++) begin
                hist_reg[i] <= hist_next[i];
            end
            deb_reg   <= deb_next;
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            count_reg <= count_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- test/bccd_tick_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bccd_tick_checker
// Passive checker for the button chord click detector. Keeps its own copy of
// the debounce histories, chord phase, timer, press count and registers,
// predicts one result per accepted tick and compares every result
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bccd_tick_checker
    import bccd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // raw_levels, elapsed_ms
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // fire, debounced_levels, chord_pressed, phase, press_count_out, pad
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    results_pending,
    output int                    results_checked,
    output int                    fire_count
);

    // Result layout, lowest bit last in the list
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [PHASE_W-1:0] phase;
        logic               chord;
        logic [7:0]         levels;
        logic               fire;
    } tick_result_t;

    localparam int RES_W = $bits(tick_result_t);

    // Predicted block state
    logic [HIST_W-1:0]  history [BUTTONS];
    logic [31:0]        debounced;
    logic [PHASE_W-1:0] phase_q;
    logic [TIME_W-1:0]  timer_q;
    logic [COUNT_W-1:0] count_q;

    // Register copies
    logic [MASK_W-1:0]  mask_r;
    logic [EVSEL_W-1:0] evsel_r;
    logic [TIME_W-1:0]  click_r;
    logic [TIME_W-1:0]  long_r;

    tick_result_t expected_ticks [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      results_checked, name, got, want));
        end
    endtask

    // Advance the predicted state by one tick and return its result
    task automatic predict_tick(input logic [RAW_W-1:0] raw,
                                input logic [ELAPSED_W-1:0] elapsed,
                                output tick_result_t res);
        logic [HIST_W-1:0] h;
        logic              sample;
        logic              pressed;
        logic              fire;
        logic [31:0]       need;
        logic [TIME_W:0]   sum;
        fire = 1'b0;

        // 4-sample debounce per button; buttons past the raw field read low
        for (int i = 0; i < BUTTONS; i++) begin
            sample = (i < RAW_W) ? raw[i] : 1'b0;
            h = {history[i][HIST_W-2:0], sample};
            history[i] = h;
            if (h == HIST_ALL_HIGH) begin
                debounced[i] = 1'b1;
            end else if (h == HIST_ALL_LOW) begin
                debounced[i] = 1'b0;
            end
        end

        need = 32'(mask_r);
        pressed = ((debounced & need) == need);

        // timer moves first, saturating
        sum = {1'b0, timer_q} + {1'b0, elapsed};
        timer_q = sum[TIME_W] ? TIMER_MAX : sum[TIME_W-1:0];

        case (phase_q)
            PH_IDLE: begin
                if (pressed) begin
                    fire = (evsel_r == EV_DOWN);
                    timer_q = '0;
                    count_q = COUNT_W'(1);
                    phase_q = PH_FIRST;
                end
            end
            PH_FIRST: begin
                if (!pressed) begin
                    fire = (evsel_r == EV_UP);
                    timer_q = '0;
                    phase_q = PH_WAIT;
                end else if (timer_q > long_r) begin
                    fire = (evsel_r == EV_LONG_START);
                    phase_q = PH_LONG;
                end
            end
            PH_WAIT: begin
                if (pressed) begin
                    fire = (evsel_r == EV_DOWN) || (evsel_r == EV_REPEAT);
                    if (count_q != COUNT_MAX) count_q = count_q + 1'b1;
                    timer_q = '0;
                    phase_q = PH_REPEAT;
                end else if (timer_q > click_r) begin
                    fire = ((count_q == COUNT_W'(1)) && (evsel_r == EV_CLICK)) ||
                           ((count_q == COUNT_W'(2)) && (evsel_r == EV_DOUBLE));
                    phase_q = PH_IDLE;
                end
            end
            PH_REPEAT: begin
                if (!pressed) begin
                    fire = (evsel_r == EV_UP);
                    if (timer_q < click_r) begin
                        timer_q = '0;
                        phase_q = PH_WAIT;
                    end else begin
                        phase_q = PH_IDLE;
                    end
                end else if (timer_q > click_r) begin
                    phase_q = PH_IDLE;
                end
            end
            PH_LONG: begin
                if (pressed) begin
                    fire = (evsel_r == EV_LONG_HOLD);
                end else begin
                    fire = (evsel_r == EV_UP);
                    phase_q = PH_IDLE;
                end
            end
            default: begin
                phase_q = PH_IDLE;
            end
        endcase

        res.fire   = fire;
        res.levels = debounced[7:0];
        res.chord  = pressed;
        res.phase  = phase_q;
        res.count  = count_q;
    endtask

    // Compare results, then predict accepted ticks, then track register writes
    always @(posedge aclk) begin : watch
        tick_result_t got;
        tick_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < BUTTONS; i++) history[i] = '0;
            debounced = '0;
            phase_q   = PH_IDLE;
            timer_q   = '0;
            count_q   = '0;
            mask_r    = CHORD_MASK_RST;
            evsel_r   = EVENT_SEL_RST;
            click_r   = CLICK_TIME_RST;
            long_r    = LONG_TIME_RST;
            expected_ticks.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_ticks.size() == 0) begin
                    report_mismatch("result transaction with no tick outstanding");
                end else begin
                    want = expected_ticks.pop_front();
                    got  = tick_result_t'(m_tdata[RES_W-1:0]);
                    check_field("fire", got.fire, want.fire);
                    check_field("debounced_levels", got.levels, want.levels);
                    check_field("chord_pressed", got.chord, want.chord);
                    check_field("phase", got.phase, want.phase);
                    check_field("press_count_out", got.count, want.count);
                    check_field("pad", int'(m_tdata[M_DATA_W-1:RES_W]), 0);
                    if (want.fire) fire_count++;
                    results_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_tick(s_tdata[RAW_W-1:0], s_tdata[RAW_W +: ELAPSED_W], want);
                expected_ticks.push_back(want);
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CHORD_MASK: mask_r  = cfg_wdata[MASK_W-1:0];
                    REG_EVENT_SEL:  evsel_r = cfg_wdata[EVSEL_W-1:0];
                    REG_CLICK_TIME: click_r = cfg_wdata[TIME_W-1:0];
                    REG_LONG_TIME:  long_r  = cfg_wdata[TIME_W-1:0];
                    default: ;
                endcase
            end
        end
        results_pending <= expected_ticks.size();
    end

endmodule

// ----- test/button_chord_click_detector_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_chord_click_detector_core_tb
// Drives tick transactions and register settings into the detector: a short
// directed click / long-press sequence, then press gestures with random
// content under several register settings and flow-control patterns, and a
// short repeat run that keeps counting presses. The checker instance
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module button_chord_click_detector_core_tb;
    import bccd_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 500;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatch_count;
    int results_pending;
    int results_checked;
    int fire_count;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int ticks_sent    = 0;
    int cycle_count   = 0;

    // long receiver hold-off, requested by toggling hold_go
    logic hold_go   = 1'b0;
    logic hold_ack  = 1'b0;
    int   hold_left = 0;

    logic [MASK_W-1:0] chord_now = CHORD_MASK_RST;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    button_chord_click_detector_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    bccd_tick_checker tick_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .results_checked (results_checked),
        .fire_count      (fire_count)
    );

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go != hold_ack) begin
            hold_ack  <= hold_go;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_pending);
            $display("button_chord_click_detector_core regression: fail");
            $finish;
        end
    end

    // One tick transaction; ready is sampled mid-cycle so the edge is race free
    task automatic send_tick(input logic [RAW_W-1:0] raw, input logic [ELAPSED_W-1:0] el);
        logic rdy;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {el, raw};
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        ticks_sent++;
    endtask

    // Stop offering ticks and wait for every result to come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (results_pending == 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_setting(input logic [CFG_DATA_W-1:0] mask,
                                input logic [CFG_DATA_W-1:0] evsel,
                                input logic [CFG_DATA_W-1:0] click,
                                input logic [CFG_DATA_W-1:0] long_t);
        write_reg(REG_CHORD_MASK, mask);
        write_reg(REG_EVENT_SEL, evsel);
        write_reg(REG_CLICK_TIME, click);
        write_reg(REG_LONG_TIME, long_t);
        cfg_wr_en <= 1'b0;
        chord_now = mask[MASK_W-1:0];
    endtask

    // Mostly small steps, now and then any 16-bit value or the maximum
    function automatic logic [ELAPSED_W-1:0] pick_elapsed(input int el_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return ELAPSED_W'($urandom);
        if (r == 3) return '1;
        return ELAPSED_W'($urandom_range(0, el_max));
    endfunction

    // Chord held, other buttons random, occasional bounce on one bit
    function automatic logic [RAW_W-1:0] press_levels();
        logic [RAW_W-1:0] v;
        v = chord_now | RAW_W'($urandom);
        if ($urandom_range(0, 99) < 6) v ^= RAW_W'(1) << $urandom_range(0, RAW_W-1);
        return v;
    endfunction

    function automatic logic [RAW_W-1:0] release_levels();
        logic [RAW_W-1:0] v;
        v = RAW_W'($urandom) & ~chord_now;
        if ($urandom_range(0, 99) < 6) v ^= RAW_W'(1) << $urandom_range(0, RAW_W-1);
        return v;
    endfunction

    // One to a few press/release cycles of the chord
    task automatic gesture(input int hold_max, input int gap_max, input int el_max);
        int presses;
        presses = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
        repeat (presses) begin
            repeat ($urandom_range(4, hold_max)) send_tick(press_levels(), pick_elapsed(el_max));
            repeat ($urandom_range(4, gap_max)) send_tick(release_levels(), pick_elapsed(el_max));
        end
    endtask

    // Gestures with some pure noise mixed in
    task automatic run_random(input int n, input int hold_max, input int gap_max,
                              input int el_max);
        int stop_at;
        stop_at = ticks_sent + n;
        while (ticks_sent < stop_at) begin
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 8)) send_tick(RAW_W'($urandom), pick_elapsed(el_max));
            end else begin
                gesture(hold_max, gap_max, el_max);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset register values: a single click on button 0
        repeat (4) send_tick(8'h01, 16'd0);
        repeat (4) send_tick(8'hfe, 16'd100);
        repeat (2) send_tick(8'h00, 16'd200);
        // long press with all buttons, timer saturating, then release
        repeat (4) send_tick(8'hff, 16'hffff);
        send_tick(8'hff, 16'hffff);
        send_tick(8'hff, 16'd1);
        repeat (4) send_tick(8'h00, 16'hffff);

        // Down events, no idling
        drain_results();
        load_setting(16'h0001, CFG_DATA_W'(EV_DOWN), 16'd40, 16'd120);
        run_random(30, 10, 10, 15);

        // Up events, sender idles
        drain_results();
        load_setting(16'h0081, CFG_DATA_W'(EV_UP), 16'd40, 16'd120);
        src_idle_pct = 74;
        run_random(30, 10, 10, 15);

        // Repeat events, receiver stalls, plus one long hold-off that fills the block
        drain_results();
        load_setting(16'h0003, CFG_DATA_W'(EV_REPEAT), 16'd40, 16'd120);
        src_idle_pct  = 0;
        snk_stall_pct = 74;
        hold_go <= ~hold_go;
        run_random(40, 10, 10, 15);

        // Double clicks, both sides idle; sender pauses halfway until drained
        drain_results();
        load_setting(16'h0001, CFG_DATA_W'(EV_DOUBLE), 16'd60, 16'd150);
        src_idle_pct  = 31;
        snk_stall_pct = 31;
        run_random(20, 10, 10, 20);
        drain_results();
        run_random(20, 10, 10, 20);

        // Long start with zero thresholds and the full chord
        drain_results();
        load_setting(16'h00ff, CFG_DATA_W'(EV_LONG_START), 16'd0, 16'd0);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        run_random(30, 8, 8, 3);

        // Long hold
        drain_results();
        load_setting(16'h00a0, CFG_DATA_W'(EV_LONG_HOLD), 16'd100, 16'd300);
        src_idle_pct = 74;
        run_random(30, 14, 10, 60);

        // Zero mask: chord always pressed; maximum thresholds, huge steps
        drain_results();
        load_setting(16'h0000, CFG_DATA_W'(EV_CLICK), 16'hffff, 16'hffff);
        src_idle_pct  = 0;
        snk_stall_pct = 74;
        run_random(25, 10, 10, 65535);

        // Wide register values: mask keeps 0xc3, event select keeps the unused code
        drain_results();
        load_setting(16'ha5c3, 16'hffff, 16'd25, 16'd80);
        src_idle_pct  = 31;
        snk_stall_pct = 31;
        run_random(30, 10, 10, 10);

        // Back to the reset thresholds on another button
        drain_results();
        load_setting(16'h0010, CFG_DATA_W'(EV_CLICK), CLICK_TIME_RST, LONG_TIME_RST);
        run_random(30, 12, 12, 80);

        // Short repeat sequence, press count climbing on every press
        drain_results();
        load_setting(16'h0001, CFG_DATA_W'(EV_REPEAT), 16'hffff, 16'hffff);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (6) begin
            repeat (4) send_tick(8'h01, 16'd0);
            repeat (4) send_tick(8'h00, 16'd0);
        end

        // Let the repeat sequence time out, then more double-click traffic
        drain_results();
        load_setting(16'h0001, CFG_DATA_W'(EV_DOUBLE), 16'd20, 16'd50);
        snk_stall_pct = 74;
        run_random(30, 10, 10, 10);

        drain_results();
        repeat (8) @(posedge aclk);

        $display("%0d ticks sent, %0d results checked, %0d events fired",
                 ticks_sent, results_checked, fire_count);
        $display("settings: every event select incl. unused, zero/full/wide masks, %s",
                 "threshold extremes, timer saturation, long receiver hold-off");
        if (mismatch_count == 0) begin
            $display("button_chord_click_detector_core regression: pass");
        end else begin
            $display("button_chord_click_detector_core regression: fail");
        end
        $finish;
    end

endmodule

// ----- button_chord_click_detector_core.f -----
design/bccd_pkg.sv
design/button_chord_click_detector_core.sv
test/bccd_tick_checker.sv
test/button_chord_click_detector_core_tb.sv
